// ----- sv/three_register_cpu_step_core_macros.svh -----
// Assertion macros for the module that checks itself.
// Both sample on the rising edge of clk_i and are switched off while rst_ni is low.
`ifndef THREE_REGISTER_CPU_STEP_CORE_MACROS_SVH
`define THREE_REGISTER_CPU_STEP_CORE_MACROS_SVH

// A plain property that must hold at every edge out of reset.
`define TRCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication from a condition to a property in the next cycle.
`define TRCS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- sv/trcs_pkg.sv -----
package trcs_pkg;

  // Depth of the byte memory; addresses are taken modulo this power of two.
  localparam int unsigned MEM_DEPTH = 256;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_EXEC = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    OP_NOP = 4'd0,
    OP_STR = 4'd1,
    OP_LDR = 4'd2,
    OP_ADD = 4'd3,
    OP_OR  = 4'd4,
    OP_AND = 4'd5,
    OP_NOT = 4'd6,
    OP_SUB = 4'd7,
    OP_JMP = 4'd8,
    OP_JN  = 4'd9,
    OP_JZ  = 4'd10,
    OP_JC  = 4'd11,
    OP_JSR = 4'd12,
    OP_NEG = 4'd13,
    OP_SHR = 4'd14,
    OP_HLT = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    MODE_DIRECT   = 2'd0,
    MODE_INDIRECT = 2'd1,
    MODE_IMM      = 2'd2,
    MODE_INDEXED  = 2'd3
  } mode_e;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] val;
    logic       neg;
    logic       zero;
    logic       carry;
    logic       upd_c;
    logic       upd_reg;
  } alu_res_t;

  function automatic logic [MEM_AW-1:0] mem_idx(input logic [7:0] a);
    return a[MEM_AW-1:0];
  endfunction

  // Instructions that consist of the opcode byte alone.
  function automatic logic is_short(input op_e op);
    return (op == OP_NOP) || (op == OP_NOT) || (op == OP_NEG) ||
           (op == OP_SHR) || (op == OP_HLT);
  endfunction

endpackage

// ----- sv/trcs_in_if.sv -----
interface trcs_in_if;
  logic                  valid;
  logic                  ready;
  trcs_pkg::action_e     action;
  logic [7:0]            addr;
  logic [7:0]            data;

  modport source (output valid, output action, output addr, output data, input ready);
  modport sink   (input valid, input action, input addr, input data, output ready);
endinterface

// ----- sv/trcs_out_if.sv -----
interface trcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pc_value;
  logic [7:0] reg_a;
  logic [7:0] reg_b;
  logic [7:0] reg_x;
  logic       neg_flag;
  logic       zero_flag;
  logic       carry_flag;
  logic       halted;
  logic [7:0] read_data;

  modport source (output valid, output pc_value, output reg_a, output reg_b, output reg_x,
                  output neg_flag, output zero_flag, output carry_flag, output halted,
                  output read_data, input ready);
  modport sink   (input valid, input pc_value, input reg_a, input reg_b, input reg_x,
                  input neg_flag, input zero_flag, input carry_flag, input halted,
                  input read_data, output ready);
endinterface

// ----- sv/three_register_cpu_step_core.sv -----
// Each item starts in S_IDLE and ends in S_DONE; in between a memory read passes S_RD, a
// one-byte instruction S_OP, and a two-byte instruction S_OP, S_OPND and S_EA, with S_IND
// for indirect mode and S_DATA for a data fetch. One item is handled at a time: the next is
// taken in S_IDLE after the result is registered; S_DONE waits while an older beat is untaken.
// Reset: registers, flags, halt mark and output valid clear at once; 256 valid bits make the
// memory read as zero immediately, with no clearing pass.
`include "three_register_cpu_step_core_macros.svh"

module three_register_cpu_step_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  trcs_in_if.sink    in_i,
  trcs_out_if.source out_o
);

  // Sequencer states. Each state that reads memory sees its data in the next state.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_OP   = 3'd2;
  localparam logic [2:0] S_OPND = 3'd3;
  localparam logic [2:0] S_IND  = 3'd4;
  localparam logic [2:0] S_EA   = 3'd5;
  localparam logic [2:0] S_DATA = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  typedef struct packed {
    logic [7:0] pc_value;
    logic [7:0] reg_a;
    logic [7:0] reg_b;
    logic [7:0] reg_x;
    logic       neg_flag;
    logic       zero_flag;
    logic       carry_flag;
    logic       halted;
    logic [7:0] read_data;
  } result_t;

  logic [2:0] state_q, state_d;
  logic [7:0] pc_q, pc_d;
  logic [7:0] a_q, a_d;
  logic [7:0] b_q, b_d;
  logic [7:0] x_q, x_d;
  logic       n_q, n_d;
  logic       z_q, z_d;
  logic       c_q, c_d;
  logic       halt_q, halt_d;
  logic [7:0] op_q, op_d;
  logic [7:0] oaddr_q, oaddr_d;
  logic [7:0] ea_q, ea_d;
  logic [7:0] rd_q, rd_d;
  result_t    out_q, out_d;
  logic       out_valid_q, out_valid_d;

  trcs_pkg::mem_req_t mem_req;
  logic [7:0]         mem_rdata;
  trcs_pkg::alu_res_t alu_res;
  trcs_pkg::op_e      alu_op;
  logic [1:0]         rsel;
  logic [7:0]         rv;
  logic               wb_en;
  logic               in_acc;

  trcs_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // In the opcode state the instruction byte is still on the memory output, so the
  // operation and register select come straight from it; later they come from op_q.
  assign alu_op = (state_q == S_OP) ? trcs_pkg::op_e'(mem_rdata[7:4])
                                    : trcs_pkg::op_e'(op_q[7:4]);
  assign rsel   = (state_q == S_OP) ? mem_rdata[3:2] : op_q[3:2];

  always_comb begin
    unique case (rsel)
      2'd0:    rv = a_q;
      2'd1:    rv = b_q;
      2'd2:    rv = x_q;
      default: rv = 8'd0;
    endcase
  end

  trcs_alu u_alu (
    .op_i   (alu_op),
    .rv_i   (rv),
    .opnd_i (mem_rdata),
    .res_o  (alu_res)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    state_d       = state_q;
    pc_d          = pc_q;
    halt_d        = halt_q;
    op_d          = op_q;
    oaddr_d       = oaddr_q;
    ea_d          = ea_q;
    rd_d          = rd_q;
    wb_en         = 1'b0;
    mem_req       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          rd_d = 8'd0;
          unique case (in_i.action)
            trcs_pkg::ACT_LOAD: begin
              mem_req.we    = 1'b1;
              mem_req.addr  = trcs_pkg::mem_idx(in_i.addr);
              mem_req.wdata = in_i.data;
              state_d       = S_DONE;
            end
            trcs_pkg::ACT_EXEC: begin
              if (halt_q) begin
                state_d = S_DONE;
              end else begin
                mem_req.re   = 1'b1;
                mem_req.addr = trcs_pkg::mem_idx(pc_q);
                state_d      = S_OP;
              end
            end
            trcs_pkg::ACT_READ: begin
              mem_req.re   = 1'b1;
              mem_req.addr = trcs_pkg::mem_idx(in_i.addr);
              state_d      = S_RD;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_RD: begin
        rd_d    = mem_rdata;
        state_d = S_DONE;
      end
      S_OP: begin
        op_d = mem_rdata;
        pc_d = pc_q + 8'd1;
        if (trcs_pkg::is_short(trcs_pkg::op_e'(mem_rdata[7:4]))) begin
          // NOT, NEG and SHR finish here; HLT sets the mark and NOP does nothing.
          wb_en = 1'b1;
          if (trcs_pkg::op_e'(mem_rdata[7:4]) == trcs_pkg::OP_HLT) begin
            halt_d = 1'b1;
          end
          state_d = S_DONE;
        end else begin
          mem_req.re   = 1'b1;
          mem_req.addr = trcs_pkg::mem_idx(pc_q + 8'd1);
          oaddr_d      = pc_q + 8'd1;
          state_d      = S_OPND;
        end
      end
      S_OPND: begin
        pc_d    = pc_q + 8'd1;
        state_d = S_EA;
        unique case (trcs_pkg::mode_e'(op_q[1:0]))
          trcs_pkg::MODE_DIRECT:  ea_d = mem_rdata;
          trcs_pkg::MODE_INDIRECT: begin
            mem_req.re   = 1'b1;
            mem_req.addr = trcs_pkg::mem_idx(mem_rdata);
            state_d      = S_IND;
          end
          trcs_pkg::MODE_IMM:     ea_d = oaddr_q;
          default:                ea_d = mem_rdata + x_q;
        endcase
      end
      S_IND: begin
        ea_d    = mem_rdata;
        state_d = S_EA;
      end
      S_EA: begin
        state_d = S_DONE;
        unique case (trcs_pkg::op_e'(op_q[7:4]))
          trcs_pkg::OP_STR: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = trcs_pkg::mem_idx(ea_q);
            mem_req.wdata = rv;
          end
          trcs_pkg::OP_LDR, trcs_pkg::OP_ADD, trcs_pkg::OP_OR,
          trcs_pkg::OP_AND, trcs_pkg::OP_SUB: begin
            mem_req.re   = 1'b1;
            mem_req.addr = trcs_pkg::mem_idx(ea_q);
            state_d      = S_DATA;
          end
          trcs_pkg::OP_JMP: pc_d = ea_q;
          trcs_pkg::OP_JN:  if (n_q) pc_d = ea_q;
          trcs_pkg::OP_JZ:  if (z_q) pc_d = ea_q;
          trcs_pkg::OP_JC:  if (c_q) pc_d = ea_q;
          trcs_pkg::OP_JSR: begin
            // The return address is the PC already moved past the operand byte.
            mem_req.we    = 1'b1;
            mem_req.addr  = trcs_pkg::mem_idx(ea_q);
            mem_req.wdata = pc_q;
            pc_d          = ea_q + 8'd1;
          end
          default: ;
        endcase
      end
      S_DATA: begin
        wb_en   = 1'b1;
        state_d = S_DONE;
      end
      default: begin
        // The result waits here until the output register is free to take it.
        if (!out_valid_q || out_o.ready) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  // Register and flag write-back; register code three discards the value but the
  // flags still follow it.
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    x_d = x_q;
    n_d = n_q;
    z_d = z_q;
    c_d = c_q;
    if (wb_en && alu_res.upd_reg) begin
      unique case (rsel)
        2'd0:    a_d = alu_res.val;
        2'd1:    b_d = alu_res.val;
        2'd2:    x_d = alu_res.val;
        default: ;
      endcase
      n_d = alu_res.neg;
      z_d = alu_res.zero;
      if (alu_res.upd_c) begin
        c_d = alu_res.carry;
      end
    end
  end

  // The output register holds one finished beat while the sequencer moves on.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if ((state_q == S_DONE) && (!out_valid_q || out_o.ready)) begin
      out_d.pc_value   = pc_q;
      out_d.reg_a      = a_q;
      out_d.reg_b      = b_q;
      out_d.reg_x      = x_q;
      out_d.neg_flag   = n_q;
      out_d.zero_flag  = z_q;
      out_d.carry_flag = c_q;
      out_d.halted     = halt_q;
      out_d.read_data  = rd_q;
      out_valid_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= 8'd0;
      a_q         <= 8'd0;
      b_q         <= 8'd0;
      x_q         <= 8'd0;
      n_q         <= 1'b0;
      z_q         <= 1'b0;
      c_q         <= 1'b0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      a_q         <= a_d;
      b_q         <= b_d;
      x_q         <= x_d;
      n_q         <= n_d;
      z_q         <= z_d;
      c_q         <= c_d;
      halt_q      <= halt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    oaddr_q <= oaddr_d;
    ea_q    <= ea_d;
    rd_q    <= rd_d;
    out_q   <= out_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.pc_value   = out_q.pc_value;
  assign out_o.reg_a      = out_q.reg_a;
  assign out_o.reg_b      = out_q.reg_b;
  assign out_o.reg_x      = out_q.reg_x;
  assign out_o.neg_flag   = out_q.neg_flag;
  assign out_o.zero_flag  = out_q.zero_flag;
  assign out_o.carry_flag = out_q.carry_flag;
  assign out_o.halted     = out_q.halted;
  assign out_o.read_data  = out_q.read_data;

  // Once set, the halt mark stays until reset.
  `TRCS_ASSERT_NEXT(a_halt_sticky, halt_q, halt_q, "halt mark cleared")
  // An accepted beat always takes the sequencer out of the idle state in the next cycle.
  `TRCS_ASSERT_NEXT(a_accept_busy, in_acc, state_q != S_IDLE, "accepted beat not started")
  // A halted machine keeps its PC through an execute beat.
  `TRCS_ASSERT_NEXT(a_halt_pc, in_acc && halt_q, $stable(pc_q), "PC moved while halted")
  // The memory is never asked to read and write in the same cycle.
  `TRCS_ASSERT(a_mem_port, !(mem_req.re && mem_req.we), "memory read and write together")

endmodule

// ----- sv/trcs_mem.sv -----
module trcs_mem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trcs_pkg::mem_req_t req_i,
  output logic [7:0]         rdata_o
);

  logic [7:0]                     mem_q [trcs_pkg::MEM_DEPTH];
  logic [trcs_pkg::MEM_DEPTH-1:0] vld_q;
  logic [7:0]                     rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  // An entry that was never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.we) begin
      vld_q[req_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= vld_q[req_i.addr] ? mem_q[req_i.addr] : 8'd0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/trcs_alu.sv -----
module trcs_alu (
  input  trcs_pkg::op_e      op_i,
  input  logic [7:0]         rv_i,
  input  logic [7:0]         opnd_i,
  output trcs_pkg::alu_res_t res_o
);

  logic [8:0] sum;
  logic [7:0] val;

  assign sum = {1'b0, rv_i} + {1'b0, opnd_i};

  always_comb begin
    val           = rv_i;
    res_o.carry   = 1'b0;
    res_o.upd_c   = 1'b0;
    res_o.upd_reg = 1'b1;
    unique case (op_i)
      trcs_pkg::OP_LDR: val = opnd_i;
      trcs_pkg::OP_ADD: begin
        val         = sum[7:0];
        res_o.carry = sum[8];
        res_o.upd_c = 1'b1;
      end
      trcs_pkg::OP_OR:  val = rv_i | opnd_i;
      trcs_pkg::OP_AND: val = rv_i & opnd_i;
      trcs_pkg::OP_NOT: val = ~rv_i;
      trcs_pkg::OP_SUB: begin
        val         = rv_i - opnd_i;
        res_o.carry = rv_i < opnd_i;
        res_o.upd_c = 1'b1;
      end
      trcs_pkg::OP_NEG: begin
        val         = 8'd0 - rv_i;
        res_o.carry = rv_i != 8'd0;
        res_o.upd_c = 1'b1;
      end
      trcs_pkg::OP_SHR: begin
        val         = {1'b0, rv_i[7:1]};
        res_o.carry = rv_i[0];
        res_o.upd_c = 1'b1;
      end
      default: res_o.upd_reg = 1'b0;
    endcase
    res_o.val  = val;
    res_o.neg  = val[7];
    res_o.zero = val == 8'd0;
  end

endmodule
